/* src/sspq_pkg.sv */
// Shared constants, codes, command/status types and the key compare for the priority queue
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int TAG_W        = 31;
    localparam int OCC_W        = 7;
    localparam int STATUS_W     = 2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                load;
        logic                search_init;
        logic                search_step;
        logic                shift_init;
        logic                shift_step;
        logic                write_new;
        logic                pop_read;
        logic                pop_commit;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                emit;
    } t_dp_cmd;

    typedef struct packed {
        logic op_pop;
        logic empty;
        logic full;
        logic search_done;
        logic shift_done;
        logic out_free;
    } t_dp_stat;

    // true when key a is served strictly before key b
    function automatic logic key_precedes(
        input logic signed [KEY_W-1:0] a,
        input logic signed [KEY_W-1:0] b,
        input logic                    largest_first
    );
        return largest_first ? (a > b) : (a < b);
    endfunction

endpackage

/* src/sspq_in_if.sv */
// Input item channel: operation, key and tag with valid/ready
`timescale 1ns / 1ps

interface sspq_in_if;
    import sspq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;

    modport source (output valid, output operation, output key, output tag, input ready);
    modport sink   (input valid, input operation, input key, input tag, output ready);
endinterface

/* src/sspq_out_if.sv */
// Result item channel: status, popped entry and occupancy with valid/ready
`timescale 1ns / 1ps

interface sspq_out_if;
    import sspq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] out_key;
    logic [TAG_W-1:0]        out_tag;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output out_key, output out_tag,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_key, input out_tag,
                    input occupancy, output ready);
endinterface

/* src/sspq_cfg_if.sv */
// Configuration write channel carrying the sort order register
`timescale 1ns / 1ps

interface sspq_cfg_if;
    logic valid;
    logic ready;
    logic sort_order;

    modport source (output valid, output sort_order, input ready);
    modport sink   (input valid, input sort_order, output ready);
endinterface

/* src/sspq_datapath.sv */
// Entry memory, circular head/count, scan and shift counters, and the result register
`timescale 1ns / 1ps

module sspq_datapath #(
    parameter int CAPACITY = sspq_pkg::DEF_CAPACITY
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  sspq_pkg::t_dp_cmd                         i_cmd,
    output sspq_pkg::t_dp_stat                        o_stat,
    input  logic                                      i_in_op,
    input  logic signed [sspq_pkg::KEY_W-1:0]         i_in_key,
    input  logic [sspq_pkg::TAG_W-1:0]                i_in_tag,
    input  logic                                      i_cfg_we,
    input  logic                                      i_cfg_order,
    input  logic                                      i_out_ready,
    output logic                                      o_out_valid,
    output logic [sspq_pkg::STATUS_W-1:0]             o_out_status,
    output logic signed [sspq_pkg::KEY_W-1:0]         o_out_key,
    output logic [sspq_pkg::TAG_W-1:0]                o_out_tag,
    output logic [sspq_pkg::OCC_W-1:0]                o_out_occ
);
    import sspq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_W + TAG_W;
    localparam logic [CW:0]   CAP_X   = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_H   = (AW+1)'(CAPACITY);

    // logical position from the head to physical memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(lidx);
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    logic [DW-1:0]             r_mem [CAPACITY];
    logic [DW-1:0]             r_rd_data;
    logic                      r_order, n_order;
    logic                      r_op;
    logic signed [KEY_W-1:0]   r_key;
    logic [TAG_W-1:0]          r_tag;
    logic [AW-1:0]             r_head, n_head;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_ins, n_ins;
    logic                      r_rd_vld, n_rd_vld;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic                      r_out_valid, n_out_valid;

    logic signed [KEY_W-1:0]   rd_key;
    logic [TAG_W-1:0]          rd_tag;
    logic                      hit;
    logic                      search_done;
    logic [CW-1:0]             found_pos;
    logic                      shift_more;
    logic [CW-1:0]             idx_dec;
    logic [CW-1:0]             pos_inc;
    logic [AW:0]               head_inc;
    logic                      rd_en;
    logic                      step_rd;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [DW-1:0]             wr_data;

    assign rd_key      = r_rd_data[DW-1:TAG_W];
    assign rd_tag      = r_rd_data[TAG_W-1:0];
    assign hit         = r_rd_vld && key_precedes(r_key, rd_key, r_order);
    assign search_done = hit || (r_idx >= r_count);
    assign found_pos   = hit ? r_pos : r_count;
    assign shift_more  = r_idx > r_ins;
    assign idx_dec     = r_idx - CW'(1);
    assign pos_inc     = r_pos + CW'(1);
    assign head_inc    = (AW+1)'(r_head) + (AW+1)'(1);

    assign o_stat.op_pop      = (r_op == OP_POP);
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.full        = (r_count == CAP_CNT);
    assign o_stat.search_done = search_done;
    assign o_stat.shift_done  = !shift_more && !r_rd_vld;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        step_rd = 1'b0;
        rd_addr = r_head;
        if (i_cmd.pop_read) begin
            rd_en   = 1'b1;
            rd_addr = r_head;
        end else if (i_cmd.search_step && (r_idx < r_count)) begin
            rd_en   = 1'b1;
            step_rd = 1'b1;
            rd_addr = phys(r_head, r_idx);
        end else if (i_cmd.shift_step && shift_more) begin
            rd_en   = 1'b1;
            step_rd = 1'b1;
            rd_addr = phys(r_head, idx_dec);
        end

        wr_en   = 1'b0;
        wr_addr = phys(r_head, r_ins);
        wr_data = {r_key, r_tag};
        if (i_cmd.write_new) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = phys(r_head, pos_inc);
            wr_data = r_rd_data;
        end
    end

    always_comb begin
        n_order     = i_cfg_we ? i_cfg_order : r_order;
        n_rd_vld    = step_rd;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_count     = r_count;
        n_head      = r_head;
        n_status    = i_cmd.set_status ? i_cmd.status : r_status;
        n_out_valid = i_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

        if (i_cmd.search_init) begin
            n_idx = '0;
        end else if (i_cmd.shift_init) begin
            n_idx = r_count;
            n_ins = found_pos;
        end else if (i_cmd.search_step && step_rd) begin
            n_idx = r_idx + CW'(1);
            n_pos = r_idx;
        end else if (i_cmd.shift_step && step_rd) begin
            n_idx = idx_dec;
            n_pos = idx_dec;
        end

        if (i_cmd.write_new) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_commit) begin
            n_count = r_count - CW'(1);
            n_head  = (head_inc == CAP_H) ? '0 : head_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_ins       <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_status    <= ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            r_order     <= n_order;
            r_rd_vld    <= n_rd_vld;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_ins       <= n_ins;
            r_count     <= n_count;
            r_head      <= n_head;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_op;
            r_key <= i_in_key;
            r_tag <= i_in_tag;
        end
        if (i_cmd.emit) begin
            o_out_status <= r_status;
            o_out_key    <= (r_status == ST_POPPED) ? rd_key : '0;
            o_out_tag    <= (r_status == ST_POPPED) ? rd_tag : '0;
            o_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* src/sspq_ctrl.sv */
// Sequencer for dispatch, ordered search, tail shift, pop and result hand-off
`timescale 1ns / 1ps

module sspq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sspq_pkg::t_dp_stat i_stat,
    output sspq_pkg::t_dp_cmd  o_cmd
);
    import sspq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_POP      = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op_pop) begin
                    if (i_stat.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_EMPTY;
                        n_state          = S_FINISH;
                    end else begin
                        o_cmd.pop_read = 1'b1;
                        n_state        = S_POP;
                    end
                end else if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.search_init = 1'b1;
                    n_state           = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.write_new  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_POPPED;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/stable_sorted_priority_queue.sv */
// Top level of the bounded sorted priority queue with stable ties
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  i_in_ch   | in  | valid / ready | operation, key (s32), tag (u31)
//  o_out_ch  | out | valid / ready | status, out_key (s32), out_tag, occupancy
//  i_cfg_ch  | in  | valid / ready | sort_order (ready is always high)
//
//  Per item: pop on empty and dropped insert go from dispatch to finish; a pop
//  reads the head, then commits; an insert runs a forward search, then
//  a tail-first shift, both paced by the one read port of the entry memory.
//  Reset: synchronous, active low; clears count, head, order and handshakes.
//  Stalls: a result waits in the output register while the next item runs;
//  the sequencer holds in its finish step until that register is free.
`timescale 1ns / 1ps

module stable_sorted_priority_queue #(
    parameter int CAPACITY = sspq_pkg::DEF_CAPACITY
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sspq_in_if.sink     i_in_ch,
    sspq_out_if.source  o_out_ch,
    sspq_cfg_if.sink    i_cfg_ch
);
    import sspq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // The order register takes a write in any cycle; writes must arrive only while idle (not enforced here).
    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = in_ready;

    // Sequencer: accept one item, walk it through search/shift or pop (or report full/empty), hand off result.
    sspq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: circular entry store (head at logical zero), scan counters and
    // the result register that decouples the output side.
    sspq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_op      (i_in_ch.operation),
        .i_in_key     (i_in_ch.key),
        .i_in_tag     (i_in_ch.tag),
        .i_cfg_we     (i_cfg_ch.valid),
        .i_cfg_order  (i_cfg_ch.sort_order),
        .i_out_ready  (o_out_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .o_out_status (o_out_ch.status),
        .o_out_key    (o_out_ch.out_key),
        .o_out_tag    (o_out_ch.out_tag),
        .o_out_occ    (o_out_ch.occupancy)
    );

endmodule

/* src/sspq_checker.sv */
// Port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps

module sspq_checker #(
    parameter int CAPACITY = sspq_pkg::DEF_CAPACITY
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [sspq_pkg::STATUS_W-1:0]       i_status,
    input logic signed [sspq_pkg::KEY_W-1:0]   i_out_key,
    input logic [sspq_pkg::TAG_W-1:0]          i_out_tag,
    input logic [sspq_pkg::OCC_W-1:0]          i_occupancy
);
    import sspq_pkg::*;

    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

    a_zero_unless_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_POPPED) |-> (i_out_key == '0) && (i_out_tag == '0))
        else $error("entry fields not zero on a non-pop result");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |-> (i_occupancy == '0))
        else $error("pop on empty reported with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_occupancy == CAP_OCC))
        else $error("dropped insert reported while not full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_key) && $stable(i_out_tag) && $stable(i_occupancy))
        else $error("stalled result changed");

endmodule

bind stable_sorted_priority_queue sspq_checker #(
    .CAPACITY (CAPACITY)
) u_sspq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_status    (o_out_ch.status),
    .i_out_key   (o_out_ch.out_key),
    .i_out_tag   (o_out_ch.out_tag),
    .i_occupancy (o_out_ch.occupancy)
);

/* tb/tb_stable_sorted_priority_queue.sv */
// Self-checking testbench for the stable sorted priority queue
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;
    import sspq_pkg::*;

    localparam int QUEUE_DEPTH  = DEF_CAPACITY;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W - 1){1'b1}}};
    localparam logic [TAG_W-1:0]        TAG_MAX = '1;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_pq_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [OCC_W-1:0]        occupancy;
    } t_pq_result;

    logic clk = 1'b0;
    logic rst_n;

    sspq_in_if  in_ch ();
    sspq_out_if out_ch ();
    sspq_cfg_if cfg_ch ();

    stable_sorted_priority_queue uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    always #6 clk = ~clk;

    // queue model: held entries in service order, head at index 0
    logic signed [KEY_W-1:0] held_keys[$];
    logic [TAG_W-1:0]        held_tags[$];
    logic                    serve_largest;

    t_pq_item   pending_items[$];
    t_pq_result expected_results[$];

    // knobs set by the sequencer on the falling edge
    bit src_idle_on;
    bit snk_idle_on;
    int hold_token;
    int cfg_token;
    logic cfg_value;

    int hold_seen;
    int hold_left;
    int cfg_done;
    int mismatch_count;
    int cycle_count;

    // Apply one item to the model and return the result it causes.
    function automatic t_pq_result predict_result(input t_pq_item it);
        t_pq_result r;
        int         pos;
        r = '0;
        if (it.op == OP_INSERT) begin
            if (held_keys.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // skip every entry the new key does not strictly beat, so ties stay FIFO
                pos = 0;
                while (pos < held_keys.size() &&
                       !(serve_largest ? ($signed(it.key) > $signed(held_keys[pos]))
                                       : ($signed(it.key) < $signed(held_keys[pos]))))
                    pos++;
                held_keys.insert(pos, it.key);
                held_tags.insert(pos, it.tag);
                r.status = ST_INSERTED;
            end
        end else if (held_keys.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_POPPED;
            r.key    = held_keys.pop_front();
            r.tag    = held_tags.pop_front();
        end
        r.occupancy = OCC_W'(held_keys.size());
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return KEY_W'(int'($urandom_range(0, 8)) - 4);  // dense ties
            4: begin
                case ($urandom_range(0, 3))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic op, input logic signed [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag);
        t_pq_item it;
        it.op  = op;
        it.key = key;
        it.tag = tag;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Hold until every item is sent and answered, then let the block settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_order(input logic largest_first);
        cfg_value = largest_first;
        cfg_token++;
        while (cfg_done != cfg_token) @(negedge clk);
    endtask

    // One random phase: drain, set the order and stall knobs, then queue n items biased by insert_pct.
    task automatic run_phase(input logic largest_first, input int n_items,
                             input int insert_pct, input bit src_idle,
                             input bit snk_idle, input bit long_hold);
        int i;
        wait_drained();
        write_order(largest_first);
        src_idle_on = src_idle;
        snk_idle_on = snk_idle;
        if (long_hold)
            hold_token++;
        for (i = 0; i < n_items; i++) begin
            add_item(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP,
                     draw_key(), TAG_W'($urandom));
        end
    endtask

    // Offer items from the pending queue; predict each one as it is taken.
    always @(posedge clk) begin : item_driver
        t_pq_item   nxt;
        t_pq_item   taken;
        t_pq_result pred;
        int         snd_wait;
        if (!rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.operation <= OP_INSERT;
            in_ch.key       <= '0;
            in_ch.tag       <= '0;
            snd_wait = 0;
            held_keys.delete();
            held_tags.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                taken.op  = in_ch.operation;
                taken.key = in_ch.key;
                taken.tag = in_ch.tag;
                pred = predict_result(taken);
                expected_results.insert(expected_results.size(), pred);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (snd_wait != 0) begin
                    snd_wait = snd_wait - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    in_ch.operation <= nxt.op;
                    in_ch.key       <= nxt.key;
                    in_ch.tag       <= nxt.tag;
                    in_ch.valid     <= 1'b1;
                    snd_wait = src_idle_on ? $urandom_range(0, 15) : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Take results, compare against the oldest expectation, stall at random.
    always @(posedge clk) begin : result_monitor
        t_pq_result got;
        t_pq_result want;
        int         snk_wait;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.status    = out_ch.status;
                got.key       = out_ch.out_key;
                got.tag       = out_ch.out_tag;
                got.occupancy = out_ch.occupancy;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: status=%0d key=%0d tag=%0d occ=%0d",
                                 got.status, got.key, got.tag, got.occupancy);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.key !== want.key ||
                        got.tag !== want.tag || got.occupancy !== want.occupancy) begin
                        mismatch_count++;
                        // fields in order status/key/tag/occupancy
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.status, want.key, want.tag, want.occupancy,
                                     got.status, got.key, got.tag, got.occupancy);
                    end
                end
                snk_wait = snk_idle_on ? $urandom_range(0, 15) : 0;
            end else if (snk_wait != 0) begin
                snk_wait = snk_wait - 1;
            end
            out_ch.ready <= (snk_wait == 0) && (hold_left == 0);
        end
    end

    // Long receiver stall: the sender keeps offering until the block backs up.
    always @(posedge clk) begin : long_stall
        if (!rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_token != hold_seen) begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_token;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin : cfg_writer
        if (!rst_n) begin
            cfg_ch.valid      <= 1'b0;
            cfg_ch.sort_order <= 1'b0;
            cfg_done          <= 0;
            serve_largest     <= 1'b0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            serve_largest <= cfg_ch.sort_order;
            cfg_done      <= cfg_done + 1;
            cfg_ch.valid  <= 1'b0;
        end else if (!cfg_ch.valid && cfg_done != cfg_token) begin
            cfg_ch.valid      <= 1'b1;
            cfg_ch.sort_order <= cfg_value;
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial begin : sequencer
        rst_n             = 1'b0;
        hold_token        = 0;
        cfg_token         = 0;
        cfg_value         = 1'b0;
        src_idle_on       = 1'b0;
        snk_idle_on       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest first: empty pop, key extremes, equal keys leave in arrival order
        write_order(1'b0);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        add_item(OP_POP,    KEY_MAX, TAG_MAX);
        add_item(OP_INSERT, KEY_MIN, TAG_MAX);
        add_item(OP_INSERT, KEY_MAX, '0);
        add_item(OP_INSERT, '0,      TAG_W'(1));
        add_item(OP_INSERT, 32'sd5,  TAG_W'(32'h2AAA_AAAA));
        add_item(OP_INSERT, 32'sd5,  TAG_W'(32'h5555_5555));
        add_item(OP_INSERT, '1,      TAG_W'(3));
        add_item(OP_INSERT, 32'sd5,  TAG_W'(7));
        repeat (7) add_item(OP_POP, '0, '0);
        add_item(OP_POP, KEY_MIN, '0);

        // largest first with ties, leave entries held across the order change
        wait_drained();
        write_order(1'b1);
        add_item(OP_INSERT, 32'sd10,  TAG_W'(1));
        add_item(OP_INSERT, -32'sd10, TAG_W'(2));
        add_item(OP_INSERT, 32'sd10,  TAG_W'(3));
        add_item(OP_INSERT, '0,       TAG_W'(4));
        add_item(OP_POP,    '0,       '0);

        // back to smallest first without re-sorting what is held
        wait_drained();
        write_order(1'b0);
        add_item(OP_INSERT, 32'sd3,   TAG_W'(5));
        add_item(OP_INSERT, -32'sd20, TAG_W'(6));

        // random phases: fill to overflow, churn, drain past empty
        run_phase(1'b1, 150, 85, 1'b1, 1'b1, 1'b0);
        run_phase(1'b0, 150, 50, 1'b0, 1'b0, 1'b1);
        run_phase(1'b1, 150, 20, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 150, 85, 1'b0, 1'b1, 1'b0);
        run_phase(1'b0, 150, 50, 1'b1, 1'b1, 1'b0);
        run_phase(1'b1, 150, 15, 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 150, 80, 1'b1, 1'b1, 1'b1);
        run_phase(1'b0, 150, 55, 1'b1, 1'b1, 1'b0);
        run_phase(1'b1, 150, 10, 1'b1, 1'b1, 1'b0);

        wait_drained();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
